>>> rtl/cld_pkg.sv
// Package for the circular list deque: sizes, command and status codes,
// and the control/status structs shared by controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package cld_pkg;

    localparam int DEPTH = 256;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = PTR_W + 1;
    localparam int CMD_W = 3;
    localparam int VAL_W = 32;
    localparam int POS_W = 16;
    localparam int STS_W = 2;
    localparam int DIV_CNT_W = $clog2(POS_W);

    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_READ_INDEX = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ_FRONT = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd5;

    localparam logic [STS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STS_W-1:0] ST_FULL  = 2'd2;

    // Commands from controller to datapath
    typedef struct packed {
        logic latch;     // capture the input transaction
        logic exec;      // decode, update pointers, write the ring
        logic div_step;  // one restoring-division step
        logic rd_issue;  // registered ring read
        logic out_load;  // load the output register
    } t_ctrl_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic rd_needed; // command reads a non-empty ring
        logic is_rd_idx; // command is read at index
        logic div_last;  // final division step in progress
    } t_dp_status;

endpackage

>>> rtl/cld_datapath.sv
// Datapath of the circular list deque: ring memory, front pointer, count,
// bit-serial modulo unit and result registers. Depends on cld_pkg.
`timescale 1ns / 1ps

module cld_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  cld_pkg::t_ctrl_cmd             i_cmd,
    output cld_pkg::t_dp_status            o_sts,
    input  logic [cld_pkg::CMD_W-1:0]      i_command,
    input  logic signed [cld_pkg::VAL_W-1:0] i_value,
    input  logic [cld_pkg::POS_W-1:0]      i_position,
    output logic [cld_pkg::STS_W-1:0]      o_status,
    output logic signed [cld_pkg::VAL_W-1:0] o_data
);

    logic [cld_pkg::VAL_W-1:0] mem [cld_pkg::DEPTH];

    logic [cld_pkg::CMD_W-1:0]     r_command;
    logic [cld_pkg::VAL_W-1:0]     r_value;
    logic [cld_pkg::POS_W-1:0]     r_dividend;
    logic [cld_pkg::CNT_W-1:0]     r_rem;
    logic [cld_pkg::DIV_CNT_W-1:0] r_div_cnt;
    logic [cld_pkg::PTR_W-1:0]     r_front;
    logic [cld_pkg::CNT_W-1:0]     r_count;
    logic [cld_pkg::STS_W-1:0]     r_res_status;
    logic                          r_res_use_rd;
    logic [cld_pkg::VAL_W-1:0]     r_rd_data;
    logic [cld_pkg::STS_W-1:0]     r_out_status;
    logic [cld_pkg::VAL_W-1:0]     r_out_data;

    logic                      full;
    logic                      empty;
    logic                      is_push;
    logic                      is_read;
    logic                      wr_en;
    logic [cld_pkg::PTR_W-1:0] wr_addr;
    logic [cld_pkg::PTR_W-1:0] rd_addr;
    logic [cld_pkg::CNT_W:0]   n_trial;
    logic [cld_pkg::CNT_W:0]   rem_diff;

    assign full    = (r_count == cld_pkg::CNT_W'(cld_pkg::DEPTH));
    assign empty   = (r_count == '0);
    assign is_push = (r_command == cld_pkg::CMD_PUSH_BACK) ||
                     (r_command == cld_pkg::CMD_PUSH_FRONT);
    assign is_read = (r_command == cld_pkg::CMD_READ_INDEX) ||
                     (r_command == cld_pkg::CMD_READ_FRONT);
    assign wr_en   = i_cmd.exec && is_push && !full;
    assign wr_addr = (r_command == cld_pkg::CMD_PUSH_BACK) ?
                     r_front + r_count[cld_pkg::PTR_W-1:0] :
                     r_front - cld_pkg::PTR_W'(1);
    assign rd_addr = (r_command == cld_pkg::CMD_READ_INDEX) ?
                     r_front + r_rem[cld_pkg::PTR_W-1:0] : r_front;

    assign o_sts.rd_needed = is_read && !empty;
    assign o_sts.is_rd_idx = (r_command == cld_pkg::CMD_READ_INDEX);
    assign o_sts.div_last  = (r_div_cnt == cld_pkg::DIV_CNT_W'(cld_pkg::POS_W - 1));

    // Shift in the next dividend bit; remainder stays below the count
    assign n_trial  = {r_rem, r_dividend[cld_pkg::POS_W-1]};
    assign rem_diff = n_trial - {1'b0, r_count};

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_command  <= i_command;
            r_value    <= i_value;
            r_dividend <= i_position;
        end
        if (i_cmd.exec) begin
            r_rem     <= '0;
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_dividend <= r_dividend << 1;
            r_div_cnt  <= r_div_cnt + cld_pkg::DIV_CNT_W'(1);
            if (n_trial >= {1'b0, r_count}) begin
                r_rem <= rem_diff[cld_pkg::CNT_W-1:0];
            end else begin
                r_rem <= n_trial[cld_pkg::CNT_W-1:0];
            end
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_data   <= r_res_use_rd ? r_rd_data : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= r_value;
        end
        if (i_cmd.rd_issue) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front      <= '0;
            r_count      <= '0;
            r_res_status <= cld_pkg::ST_OK;
            r_res_use_rd <= 1'b0;
        end else if (i_cmd.exec) begin
            r_res_status <= cld_pkg::ST_OK;
            r_res_use_rd <= 1'b0;
            case (r_command)
                cld_pkg::CMD_PUSH_BACK: begin
                    if (full) begin
                        r_res_status <= cld_pkg::ST_FULL;
                    end else begin
                        r_count <= r_count + cld_pkg::CNT_W'(1);
                    end
                end
                cld_pkg::CMD_PUSH_FRONT: begin
                    if (full) begin
                        r_res_status <= cld_pkg::ST_FULL;
                    end else begin
                        r_front <= wr_addr;
                        r_count <= r_count + cld_pkg::CNT_W'(1);
                    end
                end
                cld_pkg::CMD_POP_FRONT: begin
                    if (empty) begin
                        r_res_status <= cld_pkg::ST_EMPTY;
                    end else begin
                        r_front <= r_front + cld_pkg::PTR_W'(1);
                        r_count <= r_count - cld_pkg::CNT_W'(1);
                    end
                end
                cld_pkg::CMD_READ_INDEX, cld_pkg::CMD_READ_FRONT: begin
                    if (empty) begin
                        r_res_status <= cld_pkg::ST_EMPTY;
                    end else begin
                        r_res_use_rd <= 1'b1;
                    end
                end
                cld_pkg::CMD_CLEAR: begin
                    r_front <= '0;
                    r_count <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_status = r_out_status;
    assign o_data   = r_out_data;

endmodule

>>> rtl/cld_controller.sv
// Controller of the circular list deque: one-hot sequencer and output valid.
// Depends on cld_pkg.
`timescale 1ns / 1ps

module cld_controller (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    output logic                  o_valid,
    input  logic                  i_ready,
    input  cld_pkg::t_dp_status   i_sts,
    output cld_pkg::t_ctrl_cmd    o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_DIV  = 5'b00100,
        S_READ = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.latch = i_valid;
                if (i_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (!i_sts.rd_needed) begin
                    n_state = S_DONE;
                end else if (i_sts.is_rd_idx) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_READ;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd_issue = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                // Hold the result until the output register is free
                o_cmd.out_load = out_free;
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;

endmodule

>>> rtl/circular_list_deque_core.sv
// Top level of the circular list deque: joins controller and datapath.
// Depends on cld_pkg, cld_controller and cld_datapath.
`timescale 1ns / 1ps

// Usage:
//   Input channel (i_valid / o_ready) carries one command transaction:
//   i_command, i_value for pushes, i_position for read at index.
//   Output channel (o_valid / i_ready) returns exactly one transaction per
//   command: o_status (ok, empty, full) and o_data (element for reads, else 0).
//   Items are handled one at a time. States from accept to the next accept:
//     push, pop, clear, unused codes, empty-ring errors: idle, exec, done
//     read front: idle, exec, read, done (one registered ring read)
//     read at index: idle, exec, div, read, done; position modulo count
//     runs through a restoring divider at one bit per cycle over the
//     16 position bits. o_valid comes from a register set when done loads the result.
//   A finished result sits in the output register; the block accepts the
//   next command while it waits and only holds in its final state if a
//   second result is ready before the first is taken.
//   Reset (synchronous, active low) empties the ring, zeroes the front
//   pointer and drops any pending result. Ring contents are not cleared;
//   reads only reach entries written since the last clear.
//   When the receiver stalls, o_status and o_data hold until taken.

module circular_list_deque_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [cld_pkg::CMD_W-1:0]        i_command,
    input  logic signed [cld_pkg::VAL_W-1:0] i_value,
    input  logic [cld_pkg::POS_W-1:0]        i_position,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [cld_pkg::STS_W-1:0]        o_status,
    output logic signed [cld_pkg::VAL_W-1:0] o_data
);

    cld_pkg::t_ctrl_cmd  ctrl_cmd;
    cld_pkg::t_dp_status dp_sts;

    // Sequence each transaction and own the output handshake
    cld_controller u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (dp_sts),
        .o_cmd   (ctrl_cmd)
    );

    // Ring store, pointers, modulo unit and result registers
    cld_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (ctrl_cmd),
        .o_sts      (dp_sts),
        .i_command  (i_command),
        .i_value    (i_value),
        .i_position (i_position),
        .o_status   (o_status),
        .o_data     (o_data)
    );

endmodule

>>> rtl/cld_checker.sv
// Port-level checker for the circular list deque, bound to the top level.
// Depends on cld_pkg and circular_list_deque_core.
`timescale 1ns / 1ps

module cld_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_valid,
    input logic                             o_ready,
    input logic [cld_pkg::CMD_W-1:0]        i_command,
    input logic signed [cld_pkg::VAL_W-1:0] i_value,
    input logic [cld_pkg::POS_W-1:0]        i_position,
    input logic                             o_valid,
    input logic                             i_ready,
    input logic [cld_pkg::STS_W-1:0]        o_status,
    input logic signed [cld_pkg::VAL_W-1:0] o_data
);

    // Reset drops any pending result
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // Stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_data))
        else $error("stalled result changed");

    // Only defined status codes
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == cld_pkg::ST_OK) || (o_status == cld_pkg::ST_EMPTY) ||
                    (o_status == cld_pkg::ST_FULL))
        else $error("undefined status code");

    // Error results carry zero data
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != cld_pkg::ST_OK) |-> (o_data == '0))
        else $error("error result with nonzero data");

    // One transaction at a time: busy right after an accept
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("accepted two transactions back to back");

endmodule

bind circular_list_deque_core cld_checker u_chk (.*);
